// ----- sv/rfic_pkg.sv -----
`default_nettype none

package rfic_pkg;

    localparam int NUM_MODULES_DEFAULT = 16;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODULE_ID_BASE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_CHANNEL   = 1'd1;

    localparam logic [4:0] MODULE_ID_BASE_RESET = 5'd3;
    localparam logic [5:0] LAST_CHANNEL_RESET   = 6'd63;

    localparam logic [31:0] FRAME_START_WORD = 32'hFFFF_FFFF;
    localparam logic [31:0] FRAME_END_WORD   = 32'hE000_0000;
    localparam logic [7:0]  HEADER_TAG       = 8'hF1;
    localparam logic [15:0] HEADER_LOW_HALF  = 16'hFFFF;
    localparam logic [3:0]  NIBBLE_HEADER    = 4'hF;
    localparam logic [3:0]  NIBBLE_CHANNEL   = 4'h1;

    localparam logic [24:0] FRAME_STEP_SINGLE = 25'd1;
    localparam logic [24:0] FRAME_STEP_QUAD   = 25'd4;

    typedef enum logic [2:0] {
        KIND_OUTSIDE      = 3'd0,
        KIND_FRAME_START  = 3'd1,
        KIND_FRAME_END    = 3'd2,
        KIND_HEADER_START = 3'd3,
        KIND_HEADER_WORD  = 3'd4,
        KIND_DATA         = 3'd5
    } word_kind_t;

endpackage

`default_nettype wire

// ----- sv/readout_frame_integrity_checker.sv -----
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------------
// in       | in_valid / in_ready   | data_word
// out      | out_valid / out_ready | word_kind, module_index, flags, differences
// cfg      | cfg_write_en          | cfg_index, cfg_data
//
// One word is taken per cycle unless the output stalls on out_ready; a result
// is presented once its word is registered, then checked into the output register.
// The per-module previous frame lives in a one-port memory with registered read,
// addressed by the current module slot; the read needs no stall because each slot
// is settled before its frame word is checked.
// Reset clears the valid bit of every slot at once; no clearing pass is needed.
// While a result waits on out_ready, one more accepted word is held in the input register.
`default_nettype none

module readout_frame_integrity_checker
    import rfic_pkg::*;
#(
    parameter int NUM_MODULES = NUM_MODULES_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [31:0]            data_word,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [2:0]                  word_kind,
    output logic [3:0]                  module_index,
    output logic                        missing_frame_end,
    output logic                        header_word_bad,
    output logic [5:0]                  channels_missed,
    output logic                        channel_repeat,
    output logic                        word_count_delta_valid,
    output logic signed [24:0]          word_count_delta,
    output logic                        frame_step_valid,
    output logic signed [24:0]          frame_step,
    output logic                        frame_gap,
    output logic [23:0]                 current_frame
);

    localparam int SLOT_W  = $clog2(NUM_MODULES);
    localparam int ID_BIAS = NUM_MODULES * ((31 + NUM_MODULES - 1) / NUM_MODULES);

    // Slot index is (id - base) modulo the table size, done by restoring
    // subtraction of shifted copies of the table size.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [4:0] id,
                                                  input logic [4:0] base);
        logic [7:0] t;
        t = 8'(id) + 8'(ID_BIAS) - 8'(base);
        for (int k = 5; k >= 0; k--)
        begin
            if (14'(t) >= (14'(NUM_MODULES) << k))
            begin
                t = t - 8'(14'(NUM_MODULES) << k);
            end
        end
        return SLOT_W'(t);
    endfunction

    logic [4:0]              module_id_base_reg;
    logic [5:0]              last_channel_reg;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [31:0]             word_reg;
    logic                    advance;
    logic                    in_take;

    logic                    in_frame_reg,      in_frame_next;
    logic                    header_active_reg, header_active_next;
    logic                    seek_module_reg,   seek_module_next;
    logic signed [3:0]       position_reg,      position_next;
    logic [SLOT_W-1:0]       module_slot_reg,   module_slot_next;
    logic [23:0]             frame_number_reg,  frame_number_next;
    logic                    frame_known_reg,   frame_known_next;
    logic [23:0]             expected_words_reg, expected_words_next;
    logic [23:0]             counted_words_reg,  counted_words_next;
    logic signed [6:0]       prior_channel_reg,  prior_channel_next;

    logic [NUM_MODULES-1:0]  prior_valid_reg;
    logic [23:0]             prior_frame_mem [NUM_MODULES];
    logic [23:0]             rd_frame_reg;
    logic                    frame_slot_update;

    logic                    out_valid_reg;
    word_kind_t              word_kind_reg,              word_kind_next;
    logic [3:0]              module_index_reg,           module_index_next;
    logic                    missing_frame_end_reg,      missing_frame_end_next;
    logic                    header_word_bad_reg,        header_word_bad_next;
    logic [5:0]              channels_missed_reg,        channels_missed_next;
    logic                    channel_repeat_reg,         channel_repeat_next;
    logic                    word_count_delta_valid_reg, word_count_delta_valid_next;
    logic [24:0]             word_count_delta_reg,       word_count_delta_next;
    logic                    frame_step_valid_reg,       frame_step_valid_next;
    logic [24:0]             frame_step_reg,             frame_step_next;
    logic                    frame_gap_reg,              frame_gap_next;
    logic [23:0]             current_frame_reg,          current_frame_next;

    assign advance       = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready      = !s1_valid_reg || advance;
    assign in_take       = in_valid && in_ready;
    assign s1_valid_next = in_take || (s1_valid_reg && !advance);

    always_comb
    begin
        logic              above_one;
        logic [15:0]       lo;
        logic [15:0]       hi;
        logic [15:0]       half;
        logic              header_start;
        logic              active;
        logic signed [4:0] pos;
        logic signed [7:0] prior;
        logic signed [7:0] chan;
        logic signed [7:0] step;
        logic [7:0]        missed;
        logic [23:0]       frame_value;

        above_one   = frame_known_reg && (frame_number_reg > 24'd1);
        lo          = word_reg[15:0];
        hi          = word_reg[31:16];
        active      = header_active_reg;
        pos         = {position_reg[3], position_reg};
        prior       = {prior_channel_reg[6], prior_channel_reg};
        missed      = 8'd0;
        frame_value = {lo[11:0], hi[11:0]};
        header_start = 1'b0;
        half        = 16'd0;
        chan        = 8'sd0;
        step        = 8'sd0;

        in_frame_next       = in_frame_reg;
        seek_module_next    = seek_module_reg;
        module_slot_next    = module_slot_reg;
        frame_number_next   = frame_number_reg;
        frame_known_next    = frame_known_reg;
        expected_words_next = expected_words_reg;
        counted_words_next  = counted_words_reg;
        frame_slot_update   = 1'b0;

        word_kind_next              = KIND_OUTSIDE;
        module_index_next           = 4'(module_slot_reg);
        missing_frame_end_next      = 1'b0;
        header_word_bad_next        = 1'b0;
        channel_repeat_next         = 1'b0;
        word_count_delta_valid_next = 1'b0;
        word_count_delta_next       = 25'd0;
        frame_step_valid_next       = 1'b0;
        frame_step_next             = 25'd0;
        frame_gap_next              = 1'b0;

        if (word_reg == FRAME_START_WORD)
        begin
            word_kind_next         = KIND_FRAME_START;
            pos                    = 5'sd1;
            seek_module_next       = 1'b1;
            missing_frame_end_next = in_frame_reg && above_one;
            in_frame_next          = 1'b1;
        end
        else if (word_reg == FRAME_END_WORD)
        begin
            word_kind_next = KIND_FRAME_END;
            active         = 1'b0;
            in_frame_next  = 1'b0;
        end
        else if (in_frame_reg)
        begin
            word_kind_next = KIND_DATA;
            header_start   = seek_module_reg && (hi[15:8] == HEADER_TAG)
                             && (lo == HEADER_LOW_HALF);
            if (header_start)
            begin
                word_kind_next = KIND_HEADER_START;
                active         = 1'b1;
                if ((prior >= 8'sd0) && above_one)
                begin
                    step = $signed({2'b00, last_channel_reg}) - prior;
                    if (step > 8'sd0)
                    begin
                        missed = missed + 8'(step);
                    end
                end
                prior = -8'sd1;
                if (above_one)
                begin
                    word_count_delta_valid_next = 1'b1;
                    word_count_delta_next = {1'b0, expected_words_reg}
                                            - {1'b0, counted_words_reg};
                end
                module_slot_next = slot_of(hi[4:0], module_id_base_reg);
                pos              = 5'sd1;
                seek_module_next = 1'b0;
            end
            if (active)
            begin
                if (!header_start)
                begin
                    word_kind_next = KIND_HEADER_WORD;
                end
                if ((pos > 5'sd0) && !((hi[15:12] == NIBBLE_HEADER)
                                       && (lo[15:12] == NIBBLE_HEADER)))
                begin
                    header_word_bad_next = 1'b1;
                end
                pos = pos + 5'sd1;
                if (pos == 5'sd3)
                begin
                    expected_words_next = frame_value;
                    counted_words_next  = 24'd0;
                end
                if (pos == 5'sd5)
                begin
                    frame_number_next = frame_value;
                    frame_known_next  = 1'b1;
                    frame_slot_update = 1'b1;
                    if (prior_valid_reg[module_slot_reg] && (rd_frame_reg > 24'd1)
                        && (frame_value > 24'd1))
                    begin
                        frame_step_valid_next = 1'b1;
                        frame_step_next = {1'b0, frame_value} - {1'b0, rd_frame_reg};
                        frame_gap_next  = (frame_step_next != FRAME_STEP_SINGLE)
                                          && (frame_step_next != FRAME_STEP_QUAD);
                    end
                end
                else if (pos == 5'sd7)
                begin
                    pos              = -5'sd1;
                    active           = 1'b0;
                    seek_module_next = 1'b1;
                end
                else if (pos > 5'sd7)
                begin
                    pos = 5'sd7;
                end
            end
            else
            begin
                for (int i = 0; i < 2; i++)
                begin
                    half = word_reg[16*i +: 16];
                    if (half[15:12] == NIBBLE_CHANNEL)
                    begin
                        chan = $signed({2'b00, half[5:0]});
                        step = chan - prior;
                        if ((step > 8'sd1) && above_one)
                        begin
                            missed = missed + 8'(step - 8'sd1);
                        end
                        if (step < 8'sd0)
                        begin
                            channel_repeat_next = 1'b1;
                        end
                        prior = chan;
                    end
                end
                counted_words_next = counted_words_reg + 24'd2;
            end
        end

        header_active_next   = active;
        position_next        = pos[3:0];
        prior_channel_next   = prior[6:0];
        channels_missed_next = missed[5:0];
        current_frame_next   = frame_known_next ? frame_number_next : '1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_id_base_reg <= MODULE_ID_BASE_RESET;
            last_channel_reg   <= LAST_CHANNEL_RESET;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            in_frame_reg       <= 1'b0;
            header_active_reg  <= 1'b0;
            seek_module_reg    <= 1'b0;
            position_reg       <= 4'sd0;
            module_slot_reg    <= '0;
            frame_number_reg   <= 24'd0;
            frame_known_reg    <= 1'b0;
            expected_words_reg <= '1;
            counted_words_reg  <= '1;
            prior_channel_reg  <= -7'sd1;
            prior_valid_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_MODULE_ID_BASE: module_id_base_reg <= cfg_data[4:0];
                    CFG_LAST_CHANNEL:   last_channel_reg   <= cfg_data[5:0];
                    default:            ;
                endcase
            end
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                in_frame_reg       <= in_frame_next;
                header_active_reg  <= header_active_next;
                seek_module_reg    <= seek_module_next;
                position_reg       <= position_next;
                module_slot_reg    <= module_slot_next;
                frame_number_reg   <= frame_number_next;
                frame_known_reg    <= frame_known_next;
                expected_words_reg <= expected_words_next;
                counted_words_reg  <= counted_words_next;
                prior_channel_reg  <= prior_channel_next;
                if (frame_slot_update)
                begin
                    prior_valid_reg[module_slot_reg] <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg <= data_word;
        end
        if (advance)
        begin
            word_kind_reg              <= word_kind_next;
            module_index_reg           <= module_index_next;
            missing_frame_end_reg      <= missing_frame_end_next;
            header_word_bad_reg        <= header_word_bad_next;
            channels_missed_reg        <= channels_missed_next;
            channel_repeat_reg         <= channel_repeat_next;
            word_count_delta_valid_reg <= word_count_delta_valid_next;
            word_count_delta_reg       <= word_count_delta_next;
            frame_step_valid_reg       <= frame_step_valid_next;
            frame_step_reg             <= frame_step_next;
            frame_gap_reg              <= frame_gap_next;
            current_frame_reg          <= current_frame_next;
        end
    end

    // The slot address is set by the header start word, before its frame word,
    // so the registered read always holds the entry of the current slot.
    always_ff @(posedge clk)
    begin
        if (advance && frame_slot_update)
        begin
            prior_frame_mem[module_slot_reg] <= frame_number_next;
        end
        rd_frame_reg <= prior_frame_mem[module_slot_reg];
    end

    assign out_valid              = out_valid_reg;
    assign word_kind              = word_kind_reg;
    assign module_index           = module_index_reg;
    assign missing_frame_end      = missing_frame_end_reg;
    assign header_word_bad        = header_word_bad_reg;
    assign channels_missed        = channels_missed_reg;
    assign channel_repeat         = channel_repeat_reg;
    assign word_count_delta_valid = word_count_delta_valid_reg;
    assign word_count_delta       = $signed(word_count_delta_reg);
    assign frame_step_valid       = frame_step_valid_reg;
    assign frame_step             = $signed(frame_step_reg);
    assign frame_gap              = frame_gap_reg;
    assign current_frame          = current_frame_reg;

    a_header_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_active_reg |-> (position_reg >= 4'sd1 && position_reg <= 4'sd6))
        else $error("Header position out of range while a header is active.");

    a_slot_marked_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && frame_slot_update) |=> prior_valid_reg[$past(module_slot_reg)])
        else $error("Module slot not marked valid after its frame was stored.");

    a_gap_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_gap_reg) |-> frame_step_valid_reg)
        else $error("Frame gap flagged without a valid frame step.");

    a_data_has_no_header_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && word_kind_reg == KIND_DATA)
        |-> (!header_word_bad_reg && !word_count_delta_valid_reg && !frame_step_valid_reg))
        else $error("Header checks reported on a data transaction.");

    a_outside_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && word_kind_reg == KIND_OUTSIDE)
        |-> (channels_missed_reg == 6'd0 && !channel_repeat_reg))
        else $error("Channel checks reported outside a frame.");

endmodule

`default_nettype wire
